### hdl/ffca_pkg.sv
package ffca_pkg;

  localparam int unsigned HeapBytesDef   = 16384;
  localparam int unsigned AlignBytesDef  = 8;
  localparam int unsigned HeaderBytesDef = 8;

  typedef enum logic [0:0] {
    CmdAlloc   = 1'b0,
    CmdRelease = 1'b1
  } cmd_e;

  typedef enum logic [4:0] {
    StClear,
    StIdle,
    StAWalkRd,
    StAWalk,
    StAPrevRd,
    StAPrev,
    StASplitWr,
    StIWalkRd,
    StIWalk,
    StIPrevRd,
    StIPrev,
    StIBlkRd,
    StIBlk,
    StINxtRd,
    StINxt,
    StIWrB,
    StRelRd,
    StRel,
    StFinish,
    StOut
  } state_e;

endpackage

### hdl/ffca_if.sv
interface ffca_req_if;
  logic        valid;
  logic        ready;
  logic [0:0]  cmd;
  logic [31:0] request_size;
  logic [14:0] release_offset;
  modport source (output valid, cmd, request_size, release_offset, input ready);
  modport sink   (input valid, cmd, request_size, release_offset, output ready);
endinterface

interface ffca_rsp_if;
  logic        valid;
  logic        ready;
  logic [14:0] granted_offset;
  logic        success;
  logic [13:0] bytes_free;
  logic [13:0] lowest_free;
  modport source (output valid, granted_offset, success, bytes_free, lowest_free,
                  input ready);
  modport sink   (input valid, granted_offset, success, bytes_free, lowest_free,
                  output ready);
endinterface

### hdl/first_fit_coalescing_allocator.sv
// first-fit heap allocator with coalescing of freed neighbors
// req channel (sink): cmd 0 allocates request_size bytes, cmd 1 releases
// release_offset. rsp channel (source): one word per request with the granted
// offset, success flag, free bytes and lowest free bytes seen so far.
// block headers (size, allocated mark, next free) live in one simple dual-port
// synchronous memory with one entry per alignment slot; the free list is
// walked one header at a time (read, then decide).
// a request refused on its fields goes straight to the rsp word; a release
// walks the list up to the block, an allocation walks up to the first fit
// and again to reinsert a split remainder.
// only one request is in flight; req ready is low while a request is worked.
// after reset the memory is cleared one entry per cycle (HEAP_BYTES /
// ALIGN_BYTES entries), then the initial free block and end marker are written
// and the block starts taking requests.
// a stalled rsp word is held in the output register and no new request is
// taken until it has gone.
module first_fit_coalescing_allocator #(
  parameter int unsigned HEAP_BYTES   = ffca_pkg::HeapBytesDef,
  parameter int unsigned ALIGN_BYTES  = ffca_pkg::AlignBytesDef,
  parameter int unsigned HEADER_BYTES = ffca_pkg::HeaderBytesDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  ffca_req_if.sink  req_i,
  ffca_rsp_if.source rsp_o
);

  localparam int unsigned Hdr    = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
  localparam int unsigned EndOff = (HEAP_BYTES - Hdr) / ALIGN_BYTES * ALIGN_BYTES;
  localparam int unsigned Slots  = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned OW     = $clog2(HEAP_BYTES) + 1;   // offset width
  localparam int unsigned AW     = $clog2(Slots);
  localparam int unsigned SW     = $clog2(ALIGN_BYTES);
  localparam int unsigned MW     = 2 * OW + 1;

  localparam logic [OW-1:0] EndOffC = OW'(EndOff);
  localparam logic [OW-1:0] HdrC    = OW'(Hdr);
  localparam logic [OW-1:0] MinSplit = OW'(2 * Hdr);
  localparam logic [OW-1:0] NoPrev  = '1;

  typedef struct packed {
    logic          alloc;
    logic [OW-1:0] size;
    logic [OW-1:0] next;
  } hdr_t;

  ffca_pkg::state_e state_q, state_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  hdr_t          wdata, rd;
  logic [MW-1:0] rdata;

  logic [AW-1:0] clr_q, clr_d;
  logic [OW-1:0] head_q, head_d, free_q, free_d, low_q, low_d;
  logic [OW-1:0] blk_q, blk_d, prev_q, prev_d, nxt_q, nxt_d;
  logic [OW-1:0] w_q, w_d;           // rounded alloc size
  logic [OW-1:0] bsz_q, bsz_d;       // size of block being inserted
  logic [OW-1:0] psz_q, psz_d;       // size of prev
  logic [OW-1:0] nb_q, nb_d;         // split remainder offset
  logic [OW-1:0] nbsz_q, nbsz_d;
  logic [OW-1:0] ablk_q, ablk_d;     // block chosen by allocation
  logic          isrel_q, isrel_d;
  logic          merged_q, merged_d;
  logic          rv_q, rv_d;
  logic [14:0]   rg_q, rg_d;
  logic          rs_q, rs_d;

  logic [32:0] wfull;
  logic [32:0] wround;
  logic [OW-1:0] rel_b;

  ffca_hdr_mem #(.Depth(Slots), .Width(MW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(MW'(wdata)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );
  assign rd = hdr_t'(rdata);

  function automatic logic [AW-1:0] slot_of(input logic [OW-1:0] off);
    logic [OW-1:0] i;
    i = off >> SW;
    return (i < OW'(Slots)) ? i[AW-1:0] : AW'(Slots - 1);
  endfunction

  assign wfull  = {1'b0, req_i.request_size} + 33'(Hdr);
  assign wround = (wfull + 33'(ALIGN_BYTES - 1)) & ~33'(ALIGN_BYTES - 1);
  assign rel_b  = OW'(req_i.release_offset) - HdrC;

  assign req_i.ready         = (state_q == ffca_pkg::StIdle) && !rv_q;
  assign rsp_o.valid         = rv_q;
  assign rsp_o.granted_offset = rg_q;
  assign rsp_o.success       = rs_q;
  assign rsp_o.bytes_free    = free_q[13:0];
  assign rsp_o.lowest_free   = low_q[13:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffca_pkg::StClear;
      clr_q   <= '0;
      head_q  <= '0;
      free_q  <= EndOffC;
      low_q   <= EndOffC;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      free_q  <= free_d;
      low_q   <= low_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d; prev_q <= prev_d; nxt_q <= nxt_d; w_q <= w_d;
    bsz_q <= bsz_d; psz_q <= psz_d; nb_q <= nb_d; nbsz_q <= nbsz_d;
    ablk_q <= ablk_d; isrel_q <= isrel_d; merged_q <= merged_d;
    rg_q <= rg_d; rs_q <= rs_d;
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q; head_d = head_q; free_d = free_q; low_d = low_q;
    blk_d = blk_q; prev_d = prev_q; nxt_d = nxt_q; w_d = w_q;
    bsz_d = bsz_q; psz_d = psz_q; nb_d = nb_q; nbsz_d = nbsz_q;
    ablk_d = ablk_q; isrel_d = isrel_q; merged_d = merged_q;
    rv_d = rv_q; rg_d = rg_q; rs_d = rs_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;

    if (rv_q && rsp_o.ready) begin
      rv_d = 1'b0;
    end

    case (state_q)
      ffca_pkg::StClear: begin
        we = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(Slots - 1)) begin
          state_d = ffca_pkg::StFinish;   // write the initial headers next
          blk_d = '0;
        end
      end
      ffca_pkg::StFinish: begin
        // initial block then end marker
        we = 1'b1;
        if (blk_q == '0) begin
          waddr = '0;
          wdata = '{alloc: 1'b0, size: EndOffC, next: EndOffC};
          blk_d = EndOffC;
        end else begin
          waddr = slot_of(EndOffC);
          wdata = '{alloc: 1'b0, size: '0, next: EndOffC};
          state_d = ffca_pkg::StIdle;
        end
      end
      ffca_pkg::StIdle: begin
        if (req_i.valid && !rv_q) begin
          rg_d = '0;
          rs_d = 1'b0;
          if (req_i.cmd == ffca_pkg::CmdAlloc) begin
            w_d = wround[OW-1:0];
            if (req_i.request_size[31] || req_i.request_size == '0 ||
                wround > 33'(free_q)) begin
              state_d = ffca_pkg::StOut;
            end else begin
              blk_d = head_q;
              prev_d = NoPrev;
              state_d = ffca_pkg::StAWalkRd;
            end
          end else begin
            blk_d = rel_b;
            if (req_i.release_offset == '0 || OW'(req_i.release_offset) < HdrC ||
                rel_b[SW-1:0] != '0 || rel_b >= EndOffC) begin
              state_d = ffca_pkg::StOut;
            end else begin
              state_d = ffca_pkg::StRelRd;
            end
          end
        end
      end
      ffca_pkg::StRelRd: begin
        raddr = slot_of(blk_q);
        state_d = ffca_pkg::StRel;
      end
      ffca_pkg::StRel: begin
        if (!rd.alloc) begin
          state_d = ffca_pkg::StOut;
        end else begin
          we = 1'b1;
          waddr = slot_of(blk_q);
          wdata = '{alloc: 1'b0, size: rd.size, next: rd.next};
          free_d = free_q + rd.size;
          bsz_d = rd.size;
          isrel_d = 1'b1;
          rs_d = 1'b1;
          prev_d = NoPrev;
          nxt_d = head_q;
          state_d = ffca_pkg::StIWalkRd;
        end
      end
      // allocation walk
      ffca_pkg::StAWalkRd: begin
        raddr = slot_of(blk_q);
        state_d = ffca_pkg::StAWalk;
      end
      ffca_pkg::StAWalk: begin
        if (rd.size < w_q && blk_q != EndOffC) begin
          prev_d = blk_q;
          blk_d = rd.next;
          state_d = ffca_pkg::StAWalkRd;
        end else if (blk_q == EndOffC || rd.size < w_q) begin
          state_d = ffca_pkg::StOut;
        end else begin
          nxt_d = rd.next;
          ablk_d = blk_q;
          bsz_d = rd.size;
          if (prev_q == NoPrev) begin
            head_d = rd.next;
            state_d = ffca_pkg::StASplitWr;
          end else begin
            state_d = ffca_pkg::StAPrevRd;
          end
        end
      end
      ffca_pkg::StAPrevRd: begin
        raddr = slot_of(prev_q);
        state_d = ffca_pkg::StAPrev;
      end
      ffca_pkg::StAPrev: begin
        we = 1'b1;
        waddr = slot_of(prev_q);
        wdata = '{alloc: rd.alloc, size: rd.size, next: nxt_q};
        state_d = ffca_pkg::StASplitWr;
      end
      ffca_pkg::StASplitWr: begin
        we = 1'b1;
        waddr = slot_of(ablk_q);
        rs_d = 1'b1;
        rg_d = 15'(ablk_q + HdrC);
        isrel_d = 1'b0;
        if (bsz_q - w_q > MinSplit) begin
          wdata = '{alloc: 1'b1, size: w_q, next: nxt_q};
          nb_d = ablk_q + w_q;
          nbsz_d = bsz_q - w_q;
          free_d = free_q - w_q;
          low_d = ((free_q - w_q) < low_q) ? free_q - w_q : low_q;
          // remainder header is written when it is inserted
          blk_d = ablk_q + w_q;
          bsz_d = bsz_q - w_q;
          prev_d = NoPrev;
          nxt_d = head_q;
          state_d = ffca_pkg::StIWalkRd;
        end else begin
          wdata = '{alloc: 1'b1, size: bsz_q, next: nxt_q};
          free_d = free_q - bsz_q;
          low_d = ((free_q - bsz_q) < low_q) ? free_q - bsz_q : low_q;
          state_d = ffca_pkg::StOut;
        end
      end
      // insert blk_q (size bsz_q) into the ordered free list
      ffca_pkg::StIWalkRd: begin
        raddr = slot_of(nxt_q);
        state_d = ffca_pkg::StIWalk;
      end
      ffca_pkg::StIWalk: begin
        if (nxt_q < blk_q) begin
          prev_d = nxt_q;
          psz_d = rd.size;
          nxt_d = rd.next;
          state_d = ffca_pkg::StIWalkRd;
        end else begin
          merged_d = 1'b0;
          if (prev_q != NoPrev && prev_q + psz_q == blk_q) begin
            merged_d = 1'b1;
            blk_d = prev_q;
            bsz_d = psz_q + bsz_q;
          end
          state_d = ffca_pkg::StINxtRd;
        end
      end
      ffca_pkg::StINxtRd: begin
        raddr = slot_of(nxt_q);
        state_d = ffca_pkg::StINxt;
      end
      ffca_pkg::StINxt: begin
        we = 1'b1;
        waddr = slot_of(blk_q);
        wdata.alloc = 1'b0;
        wdata.size = bsz_q;
        wdata.next = nxt_q;
        if (blk_q + bsz_q == nxt_q) begin
          if (nxt_q != EndOffC) begin
            wdata.size = bsz_q + rd.size;
            wdata.next = rd.next;
          end else begin
            wdata.next = EndOffC;
          end
        end
        if (!merged_q && prev_q != NoPrev) begin
          state_d = ffca_pkg::StIPrevRd;
        end else begin
          if (!merged_q) begin
            head_d = blk_q;
          end
          state_d = ffca_pkg::StOut;
        end
      end
      ffca_pkg::StIPrevRd: begin
        raddr = slot_of(prev_q);
        state_d = ffca_pkg::StIPrev;
      end
      ffca_pkg::StIPrev: begin
        we = 1'b1;
        waddr = slot_of(prev_q);
        wdata = '{alloc: rd.alloc, size: rd.size, next: blk_q};
        state_d = ffca_pkg::StOut;
      end
      ffca_pkg::StOut: begin
        rv_d = 1'b1;
        state_d = ffca_pkg::StIdle;
      end
      default: state_d = ffca_pkg::StIdle;
    endcase
  end

  // unused codes kept for completeness of the walk variants
  logic unused;
  assign unused = ^{isrel_q, nb_q, nbsz_q, ffca_pkg::StIBlkRd, ffca_pkg::StIBlk,
                    ffca_pkg::StIWrB};

endmodule

### hdl/ffca_hdr_mem.sv
module ffca_hdr_mem #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Hdr = 8;
  localparam int unsigned AlignB = 8;
  localparam int unsigned EndOff = 16384 - 8;
  localparam int unsigned Slots = 16384 / 8;
  localparam int unsigned MinSplit = 16;
  localparam int unsigned NoPrev = 32'hFFFF_FFFF;

  typedef struct packed {
    ffca_pkg::cmd_e cmd;
    logic [31:0]    request_size;
    logic [14:0]    release_offset;
  } heap_op_t;

  typedef struct packed {
    logic [14:0] granted_offset;
    logic        success;
    logic [13:0] bytes_free;
    logic [13:0] lowest_free;
  } heap_rsp_t;

  logic clk_i;
  logic rst_ni;

  ffca_req_if req_if ();
  ffca_rsp_if rsp_if ();

  first_fit_coalescing_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // predicted heap state
  int unsigned blk_size [Slots];
  int unsigned blk_next [Slots];
  bit          blk_used [Slots];
  int unsigned head_off;
  int unsigned free_bytes;
  int unsigned low_mark;

  heap_op_t  pending_ops[$];
  heap_rsp_t expected_rsps[$];
  int unsigned live_offsets[$];
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;
  bit          hold_go;
  bit          hold_done;

  function automatic int unsigned slot_of(int unsigned off);
    int unsigned i;
    i = off / AlignB;
    return (i < Slots) ? i : Slots - 1;
  endfunction

  function automatic void heap_clear();
    for (int i = 0; i < Slots; i++) begin
      blk_size[i] = 0;
      blk_next[i] = 0;
      blk_used[i] = 0;
    end
    blk_next[slot_of(EndOff)] = EndOff;
    blk_size[0] = EndOff;
    blk_next[0] = EndOff;
    head_off = 0;
    free_bytes = EndOff;
    low_mark = EndOff;
  endfunction

  function automatic void link_free(int unsigned b);
    int unsigned prev;
    int unsigned nxt;
    int unsigned guard;
    prev = NoPrev;
    nxt = head_off;
    guard = 0;
    while (nxt < b && guard <= Slots) begin
      prev = nxt;
      nxt = blk_next[slot_of(nxt)];
      guard++;
    end
    if (prev != NoPrev && prev + blk_size[slot_of(prev)] == b) begin
      blk_size[slot_of(prev)] += blk_size[slot_of(b)];
      b = prev;
    end
    if (b + blk_size[slot_of(b)] == nxt) begin
      if (nxt != EndOff) begin
        blk_size[slot_of(b)] += blk_size[slot_of(nxt)];
        blk_next[slot_of(b)] = blk_next[slot_of(nxt)];
      end else begin
        blk_next[slot_of(b)] = EndOff;
      end
    end else begin
      blk_next[slot_of(b)] = nxt;
    end
    if (prev != b) begin
      if (prev == NoPrev) head_off = b;
      else blk_next[slot_of(prev)] = b;
    end
  endfunction

  function automatic int unsigned carve_block(logic [31:0] req);
    longint unsigned need;
    int unsigned prev;
    int unsigned blk;
    int unsigned guard;
    int unsigned nb;
    if (req[31] || req == 0) return 0;
    need = longint'(req) + Hdr;
    if (need % AlignB != 0) need += AlignB - need % AlignB;
    if (need > free_bytes) return 0;
    prev = NoPrev;
    blk = head_off;
    guard = 0;
    while (blk_size[slot_of(blk)] < need && blk != EndOff && guard <= Slots) begin
      prev = blk;
      blk = blk_next[slot_of(blk)];
      guard++;
    end
    if (blk == EndOff || blk_size[slot_of(blk)] < need) return 0;
    if (prev == NoPrev) head_off = blk_next[slot_of(blk)];
    else blk_next[slot_of(prev)] = blk_next[slot_of(blk)];
    if (blk_size[slot_of(blk)] - int'(need) > MinSplit) begin
      nb = blk + int'(need);
      blk_size[slot_of(nb)] = blk_size[slot_of(blk)] - int'(need);
      blk_used[slot_of(nb)] = 0;
      blk_size[slot_of(blk)] = int'(need);
      link_free(nb);
    end
    free_bytes -= blk_size[slot_of(blk)];
    if (free_bytes < low_mark) low_mark = free_bytes;
    blk_used[slot_of(blk)] = 1;
    return blk + Hdr;
  endfunction

  function automatic bit return_block(int unsigned off);
    int unsigned b;
    if (off == 0 || off < Hdr) return 0;
    b = off - Hdr;
    if (b % AlignB != 0 || b >= EndOff) return 0;
    if (!blk_used[slot_of(b)]) return 0;
    blk_used[slot_of(b)] = 0;
    free_bytes += blk_size[slot_of(b)];
    link_free(b);
    return 1;
  endfunction

  function automatic heap_rsp_t predict_heap_op(heap_op_t op);
    heap_rsp_t r;
    int unsigned g;
    g = 0;
    if (op.cmd == ffca_pkg::CmdAlloc) begin
      g = carve_block(op.request_size);
      r.success = (g != 0);
    end else begin
      r.success = return_block(32'(op.release_offset));
    end
    r.granted_offset = g[14:0];
    r.bytes_free = free_bytes[13:0];
    r.lowest_free = low_mark[13:0];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.cmd <= ffca_pkg::CmdAlloc;
      req_if.request_size <= '0;
      req_if.release_offset <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(predict_heap_op(heap_op_t'({req_if.cmd,
                                                            req_if.request_size,
                                                            req_if.release_offset})));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          heap_op_t op;
          op = pending_ops.pop_front();
          req_if.valid <= 1'b1;
          req_if.cmd <= op.cmd;
          req_if.request_size <= op.request_size;
          req_if.release_offset <= op.release_offset;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        // granted offsets feed later releases
        if (rsp_if.granted_offset != 0) live_offsets.push_back(32'(rsp_if.granted_offset));
        if (expected_rsps.size() == 0) begin
          $error("unexpected rsp word");
          fail_count++;
        end else begin
          heap_rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_if.granted_offset !== e.granted_offset) begin
            $error("granted_offset exp %0d got %0d", e.granted_offset, rsp_if.granted_offset);
            fail_count++;
          end
          if (rsp_if.success !== e.success) begin
            $error("success exp %0d got %0d", e.success, rsp_if.success);
            fail_count++;
          end
          if (rsp_if.bytes_free !== e.bytes_free) begin
            $error("bytes_free exp %0d got %0d", e.bytes_free, rsp_if.bytes_free);
            fail_count++;
          end
          if (rsp_if.lowest_free !== e.lowest_free) begin
            $error("lowest_free exp %0d got %0d", e.lowest_free, rsp_if.lowest_free);
            fail_count++;
          end
        end
      end
      rsp_if.ready <= !recv_hold && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // long receiver stall, counted here once started
  initial begin
    recv_hold = 1'b0;
    hold_done = 1'b0;
    wait (hold_go);
    recv_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    recv_hold = 1'b0;
    hold_done = 1'b1;
  end

  function automatic void queue_op(ffca_pkg::cmd_e c, logic [31:0] sz, logic [14:0] off);
    heap_op_t op;
    op.cmd = c;
    op.request_size = sz;
    op.release_offset = off;
    pending_ops.push_back(op);
  endfunction

  function automatic logic [31:0] rand_size();
    int unsigned k;
    k = $urandom_range(99, 0);
    if (k < 70) return $urandom_range(400, 1);
    if (k < 85) return $urandom_range(4000, 1);
    if (k < 90) return $urandom_range(16376, 8000);
    if (k < 95) return $urandom;
    return 0;
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = ffca_pkg::CmdAlloc;
    req_if.request_size = '0;
    req_if.release_offset = '0;
    rsp_if.ready = 1'b0;
    heap_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    queue_op(ffca_pkg::CmdAlloc, 32'd0, 15'd0);
    queue_op(ffca_pkg::CmdAlloc, 32'h8000_0000, 15'h7fff);
    queue_op(ffca_pkg::CmdAlloc, 32'hffff_ffff, 15'h7fff);
    queue_op(ffca_pkg::CmdAlloc, 32'h7fff_ffff, 15'd0);
    queue_op(ffca_pkg::CmdAlloc, 32'd16377, 15'd0);
    queue_op(ffca_pkg::CmdAlloc, 32'd1, 15'd0);
    queue_op(ffca_pkg::CmdAlloc, 32'd8, 15'd0);
    queue_op(ffca_pkg::CmdAlloc, 32'd9, 15'd0);
    queue_op(ffca_pkg::CmdAlloc, 32'd100, 15'd0);
    queue_op(ffca_pkg::CmdRelease, 32'hffff_ffff, 15'd0);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd4);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd13);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd16376);
    queue_op(ffca_pkg::CmdRelease, '0, 15'h7fff);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd24);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd24);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd8);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd40);
    queue_op(ffca_pkg::CmdAlloc, 32'd10000, 15'd0);
    queue_op(ffca_pkg::CmdAlloc, 32'd10000, 15'd0);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd56);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd16);
    queue_op(ffca_pkg::CmdAlloc, 32'd16368, 15'd0);
    queue_op(ffca_pkg::CmdRelease, '0, 15'd8);
    wait_drained();

    // random phases; frees mostly target offsets granted earlier, some random offsets
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 33 : 0;
      for (int i = 0; i < 210; i++) begin
        if (live_offsets.size() > 0 && $urandom_range(99, 0) < 45) begin
          int unsigned idx;
          logic [14:0] off;
          idx = $urandom_range(live_offsets.size() - 1, 0);
          off = 15'(live_offsets[idx]);
          // keep it around sometimes so double frees happen
          if ($urandom_range(9, 0) != 0) live_offsets.delete(idx);
          queue_op(ffca_pkg::CmdRelease, $urandom, off);
        end else if ($urandom_range(99, 0) < 8) begin
          queue_op(ffca_pkg::CmdRelease, $urandom, 15'($urandom));
        end else begin
          queue_op(ffca_pkg::CmdAlloc, rand_size(), 15'($urandom));
        end
        // wait so the live set reflects granted results
        wait_drained();
        if (ph == 2 && i == 100) begin
          for (int j = 0; j < 8; j++) begin
            queue_op(ffca_pkg::CmdAlloc, rand_size(), 15'($urandom));
          end
          hold_go = 1'b1;
          wait (hold_done);
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
